### hw/rtl/teri_pkg.sv
// Shared types and constants for the tree ensemble regression engine.
// Used by the node walker, the divider, the RAM users and the checker.
`timescale 1ns / 1ps
`default_nettype none

package teri_pkg;

    localparam int VALUE_W    = 32;
    localparam int TREE_SEL_W = 4;
    localparam int NODE_SEL_W = 8;
    localparam int FEAT_SEL_W = 6;
    localparam int CFG_W      = 5;

    localparam int DIV_STEPS  = 32;
    localparam int DIV_CNT_W  = 5;

    localparam logic CMD_NODE    = 1'b0;
    localparam logic CMD_FEATURE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NODE_RD,
        ST_NODE_CHK,
        ST_CMP,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } walk_state_t;

    // One node store entry: leaf flag, split feature, threshold or leaf value.
    typedef struct packed {
        logic                        leaf;
        logic [FEAT_SEL_W-1:0]       feat;
        logic signed [VALUE_W-1:0]   value;
    } node_t;

    typedef struct packed {
        logic                        done;
        logic signed [VALUE_W-1:0]   quotient;
    } div_res_t;

endpackage

`default_nettype wire

### hw/rtl/tree_ensemble_regression_inference.sv
// Tree ensemble regression: node and feature words load two RAMs; a last feature
// word walks trees 0..count-1 and emits the saturated sum divided by the count.
// Node and plain feature words are taken one per cycle. A prediction holds the input
// off: per tree a node read, a feature read and a compare per split level, then the
// leaf's node read and check, the serial divider and the load of the output register.
// Reset (synchronous, active low) clears the walker, output valid and sets count to 1.
`timescale 1ns / 1ps
`default_nettype none

module tree_ensemble_regression_inference import teri_pkg::*; #(
    parameter int MAX_TREES    = 16,
    parameter int TREE_DEPTH   = 7,
    parameter int MAX_FEATURES = 64
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,

    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_W-1:0]          cfg_data,

    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_cmd,
    input  wire logic [TREE_SEL_W-1:0]     s_tree_sel,
    input  wire logic [NODE_SEL_W-1:0]     s_node_sel,
    input  wire logic                      s_leaf_flag,
    input  wire logic [FEAT_SEL_W-1:0]     s_feature_sel,
    input  wire logic signed [VALUE_W-1:0] s_value,
    input  wire logic                      s_last_feature,

    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic signed [VALUE_W-1:0]      m_prediction
);

    localparam int NW             = TREE_DEPTH + 1;
    localparam int NODE_STRIDE    = 1 << NW;
    localparam int NODES_PER_TREE = NODE_STRIDE - 1;
    localparam int NODE_ENTRIES   = MAX_TREES * NODE_STRIDE;
    localparam int NAW            = $clog2(NODE_ENTRIES);
    localparam int FAW            = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int CW             = $clog2(MAX_TREES + 1);
    localparam int DPW            = $clog2(TREE_DEPTH + 1);

    walk_state_t state_reg, state_next;

    logic [CFG_W-1:0]       active_trees_reg;
    logic                   m_valid_reg;
    logic signed [VALUE_W-1:0] m_prediction_reg;

    logic [CW-1:0]          tree_cnt_reg;
    logic [CW-1:0]          cnt_reg;
    logic [NW-1:0]          idx_reg;
    logic [DPW-1:0]         depth_reg;
    logic signed [VALUE_W-1:0] sum_reg;

    logic                   accept;
    logic                   node_ok;
    logic                   feat_wr_ok;
    logic                   node_we;
    logic                   feat_we;
    logic                   walk_start;
    logic [31:0]            node_wide_w;
    logic [31:0]            node_wide_r;
    logic [31:0]            feat_wide_w;
    logic [31:0]            feat_wide_r;
    logic [31:0]            cnt_clamp;

    node_t                  node_wdata;
    node_t                  node_q;
    logic [VALUE_W-1:0]     feat_q;
    logic                   feat_ok;
    logic signed [VALUE_W-1:0] feat_x;
    logic                   go_left;
    logic                   leaf_hit;
    logic                   last_tree;
    logic [NW-1:0]          idx_left;
    logic [NW-1:0]          idx_right;
    logic signed [VALUE_W:0] sum_wide;
    logic signed [VALUE_W-1:0] sum_sat;

    logic                   div_start;
    logic                   out_load;
    div_res_t               div_res;

    // ---------------------------------------------------------------- input side
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    always_comb begin
        node_ok     = (32'(s_tree_sel) < 32'(MAX_TREES)) &&
                      (32'(s_node_sel) < 32'(NODES_PER_TREE));
        feat_wr_ok  = (32'(s_feature_sel) < 32'(MAX_FEATURES));
        node_we     = accept && (s_cmd == CMD_NODE) && node_ok;
        feat_we     = accept && (s_cmd == CMD_FEATURE) && feat_wr_ok;
        walk_start  = feat_we && s_last_feature;
        node_wide_w = (32'(s_tree_sel) << NW) | 32'(s_node_sel);
        feat_wide_w = 32'(s_feature_sel);
        node_wdata  = '{leaf: s_leaf_flag, feat: s_feature_sel, value: s_value};
    end

    always_comb begin
        if (active_trees_reg == '0) begin
            cnt_clamp = 32'd1;
        end else if (32'(active_trees_reg) > 32'(MAX_TREES)) begin
            cnt_clamp = 32'(MAX_TREES);
        end else begin
            cnt_clamp = 32'(active_trees_reg);
        end
    end

    // ---------------------------------------------------------------- stores
    // Read addresses follow the walker registers; data comes from the RAM's read register, valid in the next cycle.
    always_comb begin
        node_wide_r = (32'(tree_cnt_reg) << NW) | 32'(idx_reg);
        feat_wide_r = 32'(node_q.feat);
    end

    teri_ram #(
        .WIDTH ($bits(node_t)),
        .DEPTH (NODE_ENTRIES)
    ) u_node_ram (
        .aclk  (aclk),
        .we    (node_we),
        .waddr (node_wide_w[NAW-1:0]),
        .wdata (node_wdata),
        .raddr (node_wide_r[NAW-1:0]),
        .rdata (node_q)
    );

    teri_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_FEATURES)
    ) u_feat_ram (
        .aclk  (aclk),
        .we    (feat_we),
        .waddr (feat_wide_w[FAW-1:0]),
        .wdata (s_value),
        .raddr (feat_wide_r[FAW-1:0]),
        .rdata (feat_q)
    );

    // ---------------------------------------------------------------- walker datapath
    always_comb begin
        leaf_hit  = node_q.leaf || (depth_reg == DPW'(TREE_DEPTH));
        last_tree = (CW'(tree_cnt_reg + 1'b1) == cnt_reg);
        feat_ok   = (feat_wide_r < 32'(MAX_FEATURES));
        feat_x    = feat_ok ? $signed(feat_q) : '0;
        go_left   = (feat_x <= node_q.value);
        idx_left  = {idx_reg[NW-2:0], 1'b1};
        idx_right = idx_left + NW'(1);
        sum_wide  = {sum_reg[VALUE_W-1], sum_reg} + {node_q.value[VALUE_W-1], node_q.value};
        // clamp on signed overflow of the running sum
        if (sum_wide[VALUE_W] != sum_wide[VALUE_W-1]) begin
            sum_sat = sum_wide[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                        : {1'b0, {(VALUE_W-1){1'b1}}};
        end else begin
            sum_sat = sum_wide[VALUE_W-1:0];
        end
    end

    teri_div #(
        .DIV_W (CW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .res      (div_res)
    );

    // ---------------------------------------------------------------- control
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (walk_start) begin
                    state_next = ST_NODE_RD;
                end
            end
            ST_NODE_RD: begin
                state_next = ST_NODE_CHK;
            end
            ST_NODE_CHK: begin
                if (!leaf_hit) begin
                    state_next = ST_CMP;
                end else if (last_tree) begin
                    state_next = ST_DIV_GO;
                end else begin
                    state_next = ST_NODE_RD;
                end
            end
            ST_CMP: begin
                state_next = ST_NODE_RD;
            end
            ST_DIV_GO: begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_res.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        div_start = (state_reg == ST_DIV_GO);
        out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_valid_reg      <= 1'b0;
            active_trees_reg <= CFG_W'(1);
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                active_trees_reg <= cfg_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (walk_start) begin
            tree_cnt_reg <= '0;
            idx_reg      <= '0;
            depth_reg    <= '0;
            sum_reg      <= '0;
            cnt_reg      <= cnt_clamp[CW-1:0];
        end else if (state_reg == ST_NODE_CHK && leaf_hit) begin
            // take the leaf and advance to the next tree root
            sum_reg      <= sum_sat;
            tree_cnt_reg <= tree_cnt_reg + 1'b1;
            idx_reg      <= '0;
            depth_reg    <= '0;
        end else if (state_reg == ST_CMP) begin
            idx_reg      <= go_left ? idx_left : idx_right;
            depth_reg    <= depth_reg + 1'b1;
        end
        if (out_load) begin
            m_prediction_reg <= div_res.quotient;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_prediction = m_prediction_reg;

endmodule

`default_nettype wire

### hw/rtl/teri_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module teri_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/teri_div.sv
// Bit-serial signed divider: 32-bit dividend by a small unsigned count,
// truncating toward zero, one quotient bit per cycle. Depends on teri_pkg.
`timescale 1ns / 1ps
`default_nettype none

module teri_div import teri_pkg::*; #(
    parameter int DIV_W = 5
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic signed [VALUE_W-1:0] dividend,
    input  wire logic [DIV_W-1:0]          divisor,
    output div_res_t                       res
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  step_reg;
    logic                  neg_reg;
    logic [VALUE_W-1:0]    mag_reg;
    logic [VALUE_W-1:0]    quo_reg;
    logic [DIV_W-1:0]      rem_reg;
    logic [DIV_W-1:0]      dvs_reg;
    logic [VALUE_W-1:0]    q_out_reg;

    logic [DIV_W:0]        trial;
    logic                  fits;
    logic [DIV_W:0]        rem_step;
    logic [VALUE_W-1:0]    quo_step;
    logic                  last_step;

    always_comb begin
        trial     = {rem_reg, mag_reg[VALUE_W-1]};
        fits      = (trial >= {1'b0, dvs_reg});
        rem_step  = fits ? (trial - {1'b0, dvs_reg}) : trial;
        quo_step  = {quo_reg[VALUE_W-2:0], fits};
        last_step = (step_reg == DIV_CNT_W'(DIV_STEPS - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && last_step) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            step_reg <= '0;
            neg_reg  <= dividend[VALUE_W-1];
            mag_reg  <= dividend[VALUE_W-1] ? VALUE_W'(-dividend) : VALUE_W'(dividend);
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end else if (busy_reg) begin
            step_reg <= step_reg + 1'b1;
            mag_reg  <= {mag_reg[VALUE_W-2:0], 1'b0};
            quo_reg  <= quo_step;
            rem_reg  <= rem_step[DIV_W-1:0];
            if (last_step) begin
                // apply the sign of the dividend to the magnitude quotient
                q_out_reg <= neg_reg ? (-quo_step) : quo_step;
            end
        end
    end

    assign res.done     = done_reg;
    assign res.quotient = q_out_reg;

endmodule

`default_nettype wire

### hw/rtl/teri_checker.sv
// Port-level checks for the tree ensemble regression top level, bound to it.
// Depends on teri_pkg and tree_ensemble_regression_inference.
`timescale 1ns / 1ps
`default_nettype none

module teri_checker import teri_pkg::*; #(
    parameter int MAX_FEATURES = 64
) (
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_valid,
    input wire logic                      s_ready,
    input wire logic                      s_cmd,
    input wire logic [FEAT_SEL_W-1:0]     s_feature_sel,
    input wire logic                      s_last_feature,
    input wire logic                      m_valid,
    input wire logic                      m_ready,
    input wire logic signed [VALUE_W-1:0] m_prediction
);

    logic start_word;
    logic plain_word;

    assign start_word = s_valid && s_ready && (s_cmd == CMD_FEATURE) && s_last_feature &&
                        (32'(s_feature_sel) < 32'(MAX_FEATURES));
    assign plain_word = s_valid && s_ready && !start_word;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_prediction))
        else $error("result word changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_start_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        start_word |=> !s_ready)
        else $error("input still open after a prediction started");

    a_plain_keeps_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        plain_word |=> s_ready)
        else $error("input closed after a load word");

    a_result_reopens: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result issued while the walker is still busy");

endmodule

bind tree_ensemble_regression_inference teri_checker #(
    .MAX_FEATURES (MAX_FEATURES)
) u_teri_checker (.*);

`default_nettype wire

### tb/sv/tree_ensemble_regression_inference_tb.sv
// Self-checking bench for tree_ensemble_regression_inference: a directed table,
// then phases of grown trees and feature samples under several tree counts.
// Depends on teri_pkg and the RTL top only; expected means come from a local walker.
`timescale 1ns / 1ps

module tree_ensemble_regression_inference_tb;
    import teri_pkg::*;

    localparam int N_TREES    = 16;
    localparam int TREE_DEPTH = 7;
    localparam int N_FEATS    = 64;
    localparam int N_NODES    = (1 << (TREE_DEPTH + 1)) - 1;
    localparam int DRILL_ROWS = 24;
    localparam int PHASE_WORDS = 145;
    localparam int WORD_CAP   = 1250;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE     = 12;
    localparam int LIMIT      = 3000000;
    localparam int EXP_DEPTH  = 2048;
    localparam longint SUM_MAX = 64'sd2147483647;
    localparam longint SUM_MIN = -64'sd2147483648;

    typedef struct packed {
        logic                      cmd;
        logic [TREE_SEL_W-1:0]     tree;
        logic [NODE_SEL_W-1:0]     node;
        logic                      leaf;
        logic [FEAT_SEL_W-1:0]     feat;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } word_t;

    typedef struct packed {
        word_t                     w;
        logic                      typed;
        logic signed [VALUE_W-1:0] mean;
    } row_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_W-1:0]          cfg_data;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_cmd;
    logic [TREE_SEL_W-1:0]     s_tree_sel;
    logic [NODE_SEL_W-1:0]     s_node_sel;
    logic                      s_leaf_flag;
    logic [FEAT_SEL_W-1:0]     s_feature_sel;
    logic signed [VALUE_W-1:0] s_value;
    logic                      s_last_feature;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [VALUE_W-1:0] m_prediction;

    // Local copy of the forest and feature vector
    bit                        node_written [N_TREES][N_NODES];
    bit                        node_leaf    [N_TREES][N_NODES];
    logic [FEAT_SEL_W-1:0]     node_feat    [N_TREES][N_NODES];
    logic signed [VALUE_W-1:0] node_val     [N_TREES][N_NODES];
    bit                        feat_written [N_FEATS];
    logic signed [VALUE_W-1:0] feat_val     [N_FEATS];
    logic [CFG_W-1:0]          tree_count;

    // Ring of expected means, written at the input side, read at the result side
    logic signed [VALUE_W-1:0] expected_means [EXP_DEPTH];
    int  exp_wr        = 0;
    int  exp_rd        = 0;
    int  mismatches    = 0;
    int  means_checked = 0;
    int  words_sent    = 0;
    int  cycle_count   = 0;
    bit  tx_eager      = 1'b0;
    bit  rx_eager      = 1'b0;
    bit  rx_hold_req   = 1'b0;

    tree_ensemble_regression_inference #(
        .MAX_TREES    (N_TREES),
        .TREE_DEPTH   (TREE_DEPTH),
        .MAX_FEATURES (N_FEATS)
    ) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_tree_sel     (s_tree_sel),
        .s_node_sel     (s_node_sel),
        .s_leaf_flag    (s_leaf_flag),
        .s_feature_sel  (s_feature_sel),
        .s_value        (s_value),
        .s_last_feature (s_last_feature),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_prediction   (m_prediction)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int trees_used();
        if (tree_count == 0) return 1;
        if (tree_count > N_TREES) return N_TREES;
        return int'(tree_count);
    endfunction

    // Walk one tree; gap_idx is -1 when every entry read was written,
    // the unwritten node position, or -2 for an unwritten feature.
    function automatic void walk_tree(input int t, output logic signed [VALUE_W-1:0] leaf_val,
                                      output int gap_idx, output int gap_depth);
        int idx;
        int depth;
        int f;
        bit done;
        idx = 0;
        depth = 0;
        done = 1'b0;
        gap_idx = -1;
        gap_depth = 0;
        leaf_val = '0;
        while (!done) begin
            if (!node_written[t][idx]) begin
                gap_idx = idx;
                gap_depth = depth;
                done = 1'b1;
            end else if (depth == TREE_DEPTH || node_leaf[t][idx]) begin
                leaf_val = node_val[t][idx];
                done = 1'b1;
            end else begin
                f = int'(node_feat[t][idx]);
                if (!feat_written[f]) begin
                    gap_idx = -2;
                    done = 1'b1;
                end else begin
                    idx = (feat_val[f] <= node_val[t][idx]) ? 2 * idx + 1 : 2 * idx + 2;
                    depth++;
                end
            end
        end
    endfunction

    // Saturating sum of leaf values over the active trees, then truncating mean
    function automatic logic signed [VALUE_W-1:0] forest_mean(output bit clean);
        longint sum;
        int n;
        int gi;
        int gd;
        logic signed [VALUE_W-1:0] lv;
        n = trees_used();
        sum = 0;
        clean = 1'b1;
        for (int t = 0; t < n; t++) begin
            walk_tree(t, lv, gi, gd);
            if (gi != -1) clean = 1'b0;
            sum = sum + longint'(lv);
            if (sum > SUM_MAX) sum = SUM_MAX;
            if (sum < SUM_MIN) sum = SUM_MIN;
        end
        return 32'(sum / longint'(n));
    endfunction

    function automatic void absorb_word(input word_t w, output bit fires,
                                        output logic signed [VALUE_W-1:0] mean);
        bit clean;
        fires = 1'b0;
        mean = '0;
        if (w.cmd == CMD_NODE) begin
            // node positions past the last heap slot are dropped
            if (int'(w.node) < N_NODES) begin
                node_written[w.tree][w.node] = 1'b1;
                node_leaf[w.tree][w.node]    = w.leaf;
                node_feat[w.tree][w.node]    = w.feat;
                node_val[w.tree][w.node]     = w.value;
            end
        end else begin
            feat_written[w.feat] = 1'b1;
            feat_val[w.feat]     = w.value;
            if (w.last) begin
                mean = forest_mean(clean);
                fires = 1'b1;
            end
        end
    endfunction

    function automatic logic signed [VALUE_W-1:0] rand_q16();
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2, 3:    return 32'($urandom);
            default: return 32'($urandom_range(0, 32'h001f_ffff)) - 32'h0010_0000;
        endcase
    endfunction

    function automatic word_t random_word();
        word_t w;
        w.cmd   = 1'($urandom_range(0, 1));
        w.tree  = 4'($urandom_range(0, 15));
        w.node  = 8'($urandom_range(0, 255));
        w.leaf  = 1'($urandom_range(0, 1));
        w.feat  = 6'($urandom_range(0, 63));
        w.value = rand_q16();
        w.last  = 1'($urandom_range(0, 1));
        return w;
    endfunction

    // Extend the forest: mostly fill the first hole that the current sample would fall into,
    // else rewrite a node on a random path; sometimes send a node word at a random position.
    function automatic word_t grow_node();
        word_t w;
        int t;
        int idx;
        int depth;
        int gi;
        int gd;
        bit found;
        logic signed [VALUE_W-1:0] lv;
        w = random_word();
        w.cmd = CMD_NODE;
        if ($urandom_range(0, 9) == 0) return w;
        found = 1'b0;
        idx = 0;
        depth = 0;
        if ($urandom_range(0, 3) != 0) begin
            for (t = 0; t < trees_used(); t++) begin
                walk_tree(t, lv, gi, gd);
                if (!found && gi >= 0) begin
                    found = 1'b1;
                    w.tree = 4'(t);
                    idx = gi;
                    depth = gd;
                end
            end
        end
        if (!found) begin
            t = int'(w.tree);
            while (depth < TREE_DEPTH && node_written[t][idx] && !node_leaf[t][idx]
                   && $urandom_range(0, 4) != 0) begin
                idx = 2 * idx + 1 + int'($urandom_range(0, 1));
                depth++;
            end
        end
        w.node = 8'(idx);
        if (depth == TREE_DEPTH)
            w.leaf = 1'($urandom_range(0, 1));
        else
            w.leaf = ($urandom_range(0, 99) < 30 + 10 * depth);
        return w;
    endfunction

    // Feature word; ask for a prediction only when every walk stays on written entries
    function automatic word_t pick_feature_word();
        word_t w;
        logic signed [VALUE_W-1:0] old_val;
        bit old_written;
        bit clean;
        w = random_word();
        w.cmd = CMD_FEATURE;
        w.last = 1'b0;
        if ($urandom_range(0, 2) == 0) begin
            old_val = feat_val[w.feat];
            old_written = feat_written[w.feat];
            feat_val[w.feat] = w.value;
            feat_written[w.feat] = 1'b1;
            void'(forest_mean(clean));
            feat_val[w.feat] = old_val;
            feat_written[w.feat] = old_written;
            w.last = clean;
        end
        return w;
    endfunction

    function automatic row_t mk_row(input logic cmd, input int tree, input int node,
                                    input logic leaf, input int feat, input logic [31:0] value,
                                    input logic last, input logic typed, input logic [31:0] mean);
        row_t r;
        r.w.cmd   = cmd;
        r.w.tree  = 4'(tree);
        r.w.node  = 8'(node);
        r.w.leaf  = leaf;
        r.w.feat  = 6'(feat);
        r.w.value = value;
        r.w.last  = last;
        r.typed   = typed;
        r.mean    = mean;
        return r;
    endfunction

    task automatic send_word(input word_t w, input logic typed,
                             input logic signed [VALUE_W-1:0] typed_mean);
        int gap;
        bit fires;
        logic signed [VALUE_W-1:0] mean;
        gap = tx_eager ? 0 : int'($urandom_range(0, 6));
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_cmd          <= w.cmd;
        s_tree_sel     <= w.tree;
        s_node_sel     <= w.node;
        s_leaf_flag    <= w.leaf;
        s_feature_sel  <= w.feat;
        s_value        <= w.value;
        s_last_feature <= w.last;
        do @(posedge aclk); while (!s_ready);
        absorb_word(w, fires, mean);
        if (fires) begin
            expected_means[exp_wr % EXP_DEPTH] = typed ? typed_mean : mean;
            exp_wr++;
        end
        words_sent++;
    endtask

    task automatic release_input();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (exp_wr != exp_rd) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_tree_count(input logic [CFG_W-1:0] n);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        do @(posedge aclk); while (!cfg_ready);
        tree_count = n;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random back-pressure, one long hold on request
    initial begin
        int wait_n;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 19) == 0) rx_eager = !rx_eager;
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                wait_n = HOLD_CYCLES;
            end else begin
                wait_n = rx_eager ? 0 : int'($urandom_range(0, 6));
            end
            if (wait_n > 0) begin
                m_ready <= 1'b0;
                repeat (wait_n) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        logic signed [VALUE_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (exp_wr == exp_rd) begin
                $display("%0t: prediction with none pending: expected nothing, got %h",
                         $time, m_prediction);
                mismatches++;
            end else begin
                want = expected_means[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (m_prediction !== want) begin
                    $display("%0t: prediction mismatch: expected %h, got %h",
                             $time, want, m_prediction);
                    mismatches++;
                end
                means_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        row_t drill [DRILL_ROWS];
        logic [CFG_W-1:0] count_plan [8];
        logic [CFG_W-1:0] next_count;
        word_t w;
        int random_words;
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_cmd          = CMD_NODE;
        s_tree_sel     = '0;
        s_node_sel     = '0;
        s_leaf_flag    = 1'b0;
        s_feature_sel  = '0;
        s_value        = '0;
        s_last_feature = 1'b0;
        tree_count     = 5'd1;
        random_words   = 0;
        count_plan = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd7, 5'd16, 5'd12, 5'd3};

        drill[0]  = mk_row(CMD_FEATURE, 0, 0,   0, 0,  32'h0000_0000, 0, 0, 0);
        drill[1]  = mk_row(CMD_FEATURE, 0, 0,   0, 63, 32'h8000_0000, 0, 0, 0);
        drill[2]  = mk_row(CMD_NODE,    0, 0,   1, 0,  32'h7fff_ffff, 0, 0, 0);
        drill[3]  = mk_row(CMD_FEATURE, 0, 0,   0, 0,  32'h1234_5678, 1, 1, 32'h7fff_ffff);
        drill[4]  = mk_row(CMD_NODE,    0, 0,   1, 63, 32'h8000_0000, 0, 0, 0);
        drill[5]  = mk_row(CMD_FEATURE, 0, 0,   0, 63, 32'h8000_0000, 1, 1, 32'h8000_0000);
        // node position past the tree: must leave the root alone
        drill[6]  = mk_row(CMD_NODE,    0, 255, 1, 0,  32'h0000_0001, 0, 0, 0);
        drill[7]  = mk_row(CMD_FEATURE, 0, 0,   0, 0,  32'h0000_0000, 1, 1, 32'h8000_0000);
        drill[8]  = mk_row(CMD_NODE,    0, 0,   0, 63, 32'h8000_0000, 0, 0, 0);
        drill[9]  = mk_row(CMD_NODE,    0, 1,   1, 0,  32'h0001_0000, 0, 0, 0);
        drill[10] = mk_row(CMD_NODE,    0, 2,   1, 0,  32'hffff_0000, 0, 0, 0);
        // equal to the threshold goes left, one above goes right
        drill[11] = mk_row(CMD_FEATURE, 0, 0,   0, 63, 32'h8000_0000, 1, 1, 32'h0001_0000);
        drill[12] = mk_row(CMD_FEATURE, 0, 0,   0, 63, 32'h8000_0001, 1, 1, 32'hffff_0000);
        drill[13] = mk_row(CMD_NODE,    0, 1,   0, 0,  32'h7fff_ffff, 0, 0, 0);
        drill[14] = mk_row(CMD_NODE,    0, 3,   0, 0,  32'h7fff_ffff, 0, 0, 0);
        drill[15] = mk_row(CMD_NODE,    0, 7,   0, 0,  32'h7fff_ffff, 0, 0, 0);
        drill[16] = mk_row(CMD_NODE,    0, 15,  0, 0,  32'h7fff_ffff, 0, 0, 0);
        drill[17] = mk_row(CMD_NODE,    0, 31,  0, 0,  32'h7fff_ffff, 0, 0, 0);
        drill[18] = mk_row(CMD_NODE,    0, 63,  0, 0,  32'h7fff_ffff, 0, 0, 0);
        // bottom-level node without its leaf flag still ends the walk
        drill[19] = mk_row(CMD_NODE,    0, 127, 0, 63, 32'h0042_0000, 0, 0, 0);
        drill[20] = mk_row(CMD_FEATURE, 0, 0,   0, 63, 32'h8000_0000, 1, 1, 32'h0042_0000);
        // last flag on a node word starts nothing
        drill[21] = mk_row(CMD_NODE,    0, 0,   0, 63, 32'h8000_0000, 1, 0, 0);
        drill[22] = mk_row(CMD_NODE,    15, 254, 1, 63, 32'h7fff_ffff, 0, 0, 0);
        drill[23] = mk_row(CMD_FEATURE, 0, 0,   0, 63, 32'h7fff_ffff, 1, 1, 32'hffff_0000);

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < DRILL_ROWS; r++)
            send_word(drill[r].w, drill[r].typed, drill[r].mean);

        for (int ph = 0; ph < 8 || (means_checked < 48 && random_words < WORD_CAP); ph++) begin
            release_input();
            drain_results();
            if (ph < 8 && ph != 4 && ph != 6)
                next_count = count_plan[ph];
            else
                next_count = 5'($urandom_range(0, 31));
            set_tree_count(next_count);
            if (ph == 2) rx_hold_req = 1'b1;
            if (ph == 0) begin
                // load the whole feature vector before growing trees
                for (int f = 0; f < N_FEATS; f++) begin
                    w = pick_feature_word();
                    w.feat = 6'(f);
                    w.last = 1'b0;
                    send_word(w, 1'b0, '0);
                end
            end
            for (int k = 0; k < PHASE_WORDS && random_words < WORD_CAP; k++) begin
                if (k == PHASE_WORDS / 2) begin
                    release_input();
                    drain_results();
                end
                if ($urandom_range(0, 29) == 0) tx_eager = !tx_eager;
                w = $urandom_range(0, 1) ? grow_node() : pick_feature_word();
                send_word(w, 1'b0, '0);
                if (!(w.cmd == CMD_NODE && int'(w.node) >= N_NODES)) random_words++;
            end
        end

        release_input();
        drain_results();
        repeat (500) @(posedge aclk);

        $display("Run covered %0d words (%0d random) and checked %0d predictions,",
                 words_sent, random_words, means_checked);
        $display("over tree counts 0 to 31, saturating sums and a long output stall.");
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
